// ===== rtl/core/qypr_pkg.sv =====
// shared types, constants and the arctangent table for the quaternion to euler block
// no dependencies
package qypr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = 5;
    localparam int XW            = 40;   // cordic x/y width, q28 values with gain headroom
    localparam int ZW            = 36;   // angle accumulator, q30 radians
    localparam int LATENCY       = 2 * CORDIC_STAGES + 9;

    localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;

    typedef struct packed {
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cord;

    // floor(atan(2^-i) * 2^30)
    function automatic logic signed [ZW-1:0] atan_q30(input logic [IDX_W-1:0] idx);
        logic signed [ZW-1:0] a;
        case (idx)
            5'd0:  a = 36'sd843314856;
            5'd1:  a = 36'sd497837829;
            5'd2:  a = 36'sd263043836;
            5'd3:  a = 36'sd133525158;
            5'd4:  a = 36'sd67021686;
            5'd5:  a = 36'sd33543515;
            5'd6:  a = 36'sd16775850;
            5'd7:  a = 36'sd8388437;
            5'd8:  a = 36'sd4194282;
            5'd9:  a = 36'sd2097149;
            5'd10: a = 36'sd1048575;
            5'd11: a = 36'sd524287;
            5'd12: a = 36'sd262143;
            5'd13: a = 36'sd131071;
            5'd14: a = 36'sd65535;
            5'd15: a = 36'sd32767;
            5'd16: a = 36'sd16383;
            5'd17: a = 36'sd8191;
            5'd18: a = 36'sd4095;
            5'd19: a = 36'sd2047;
            5'd20: a = 36'sd1023;
            5'd21: a = 36'sd511;
            5'd22: a = 36'sd255;
            5'd23: a = 36'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

    // left half-plane vectors are flipped and start from +/- pi
    function automatic t_cord cord_pre(input logic signed [XW-1:0] x,
                                       input logic signed [XW-1:0] y);
        t_cord c;
        c.zero = (x == '0) && (y == '0);
        if (x[XW-1]) begin
            c.x = -x;
            c.y = -y;
            c.z = y[XW-1] ? -PI_Q30 : PI_Q30;
        end else begin
            c.x = x;
            c.y = y;
            c.z = '0;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/quaternion_to_yaw_pitch_roll_top.sv =====
// quaternion to yaw, pitch and roll in whole degrees
// depends on qypr_pkg and qypr_cell
//
// usage:
//   a request is taken at each rising edge with start high and busy low; busy
//   is always low, so one quaternion may be issued in every cycle
//   quat_w/x/y/z are signed q2.14 (16384 is one)
//   each request gives exactly one result: o_valid is high for one cycle with
//   o_yaw_deg, o_pitch_deg and o_roll_deg, each floor(angle*180/pi + 180)
//   clamped to 0..360
// the two cordic cell rows are chained: roll/yaw first, then pitch, which
//   needs the roll magnitude
// throughput: one request per cycle, results leave in request order
// reset: synchronous active low, clears the valid pipeline; requests in
//   flight are dropped
// the receiver cannot stall: results are shown for one cycle only
module quaternion_to_yaw_pitch_roll_top
    import qypr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    output logic [8:0]         o_yaw_deg,
    output logic [8:0]         o_pitch_deg,
    output logic [8:0]         o_roll_deg
);

    localparam logic signed [XW-1:0] ONE_Q28   = 40'sd268435456;
    localparam logic [15:0]          INV_GAIN  = 16'd39797;
    localparam logic signed [27:0]   RAD2DEG   = 28'sd60078979;
    localparam logic signed [63:0]   DEG_OFS   = 64'sd180 <<< 50;

    typedef struct packed {
        logic signed [XW-1:0] gx;
        logic                 gzneg;
    } t_side1;

    typedef struct packed {
        logic signed [ZW-1:0] yaw;
        logic signed [ZW-1:0] roll;
        logic                 gzneg;
    } t_side2;

    // valid pipeline, one bit per register stage
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[LATENCY-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[LATENCY-1];

    // stage 1: input capture
    logic signed [15:0] r_w, r_x, r_y, r_z;
    always_ff @(posedge i_clk) begin
        r_w <= i_quat_w;
        r_x <= i_quat_x;
        r_y <= i_quat_y;
        r_z <= i_quat_z;
    end

    // stage 2: component products, exact q28
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_wx, r_yz;
    always_ff @(posedge i_clk) begin
        r_ww <= r_w * r_w;
        r_xx <= r_x * r_x;
        r_yy <= r_y * r_y;
        r_zz <= r_z * r_z;
        r_xy <= r_x * r_y;
        r_wz <= r_w * r_z;
        r_xz <= r_x * r_z;
        r_wy <= r_w * r_y;
        r_wx <= r_w * r_x;
        r_yz <= r_y * r_z;
    end

    // stage 3: yaw terms and gravity vector
    logic signed [XW-1:0] r_yaw_x, r_yaw_y, r_gx, r_gy, r_gz;
    always_ff @(posedge i_clk) begin
        r_yaw_y <= (XW'(r_xy) <<< 1) - (XW'(r_wz) <<< 1);
        r_yaw_x <= (XW'(r_ww) <<< 1) + (XW'(r_xx) <<< 1) - ONE_Q28;
        r_gx    <= (XW'(r_xz) - XW'(r_wy)) <<< 1;
        r_gy    <= (XW'(r_wx) + XW'(r_yz)) <<< 1;
        r_gz    <= XW'(r_ww) - XW'(r_xx) - XW'(r_yy) + XW'(r_zz);
    end

    // stage 4: quadrant fix-up for yaw and roll
    t_cord  c_yaw  [CORDIC_STAGES+1];
    t_cord  c_roll [CORDIC_STAGES+1];
    t_side1 r_s1   [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        c_yaw[0]       <= cord_pre(r_yaw_x, r_yaw_y);
        c_roll[0]      <= cord_pre(r_gz, r_gy);
        r_s1[0].gx     <= r_gx;
        r_s1[0].gzneg  <= r_gz[XW-1];
    end

    // first cell row: yaw and roll side by side
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_row1
        qypr_cell u_yaw (
            .i_clk (i_clk),
            .i_idx (IDX_W'(g)),
            .i_in  (c_yaw[g]),
            .o_out (c_yaw[g+1])
        );
        qypr_cell u_roll (
            .i_clk (i_clk),
            .i_idx (IDX_W'(g)),
            .i_in  (c_roll[g]),
            .o_out (c_roll[g+1])
        );
        always_ff @(posedge i_clk) begin
            r_s1[g+1] <= r_s1[g];
        end
    end

    // magnitude: raw cordic x scaled by 1/gain in q16; x is never negative here
    logic [XW+15:0]       mag_prod;
    logic signed [XW-1:0] r_mag;
    logic signed [XW-1:0] r_gx_m;
    t_side2               r_s2_in;

    assign mag_prod = (XW+16)'(unsigned'(c_roll[CORDIC_STAGES].x)) * (XW+16)'(INV_GAIN);

    always_ff @(posedge i_clk) begin
        r_mag          <= XW'(mag_prod >> 16);
        r_gx_m         <= r_s1[CORDIC_STAGES].gx;
        r_s2_in.yaw    <= c_yaw[CORDIC_STAGES].zero  ? '0 : c_yaw[CORDIC_STAGES].z;
        r_s2_in.roll   <= c_roll[CORDIC_STAGES].zero ? '0 : c_roll[CORDIC_STAGES].z;
        r_s2_in.gzneg  <= r_s1[CORDIC_STAGES].gzneg;
    end

    // pitch fix-up and second cell row
    t_cord  c_pitch [CORDIC_STAGES+1];
    t_side2 r_s2    [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        c_pitch[0] <= cord_pre(r_mag, r_gx_m);
        r_s2[0]    <= r_s2_in;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_row2
        qypr_cell u_pitch (
            .i_clk (i_clk),
            .i_idx (IDX_W'(g)),
            .i_in  (c_pitch[g]),
            .o_out (c_pitch[g+1])
        );
        always_ff @(posedge i_clk) begin
            r_s2[g+1] <= r_s2[g];
        end
    end

    // fold pitch when gravity z points down
    logic signed [ZW-1:0] pitch_raw;
    logic signed [ZW-1:0] n_pitch;
    logic signed [ZW-1:0] r_ang [3];

    always_comb begin
        pitch_raw = c_pitch[CORDIC_STAGES].zero ? '0 : c_pitch[CORDIC_STAGES].z;
        n_pitch   = pitch_raw;
        if (r_s2[CORDIC_STAGES].gzneg) begin
            if (pitch_raw > 0) begin
                n_pitch = PI_Q30 - pitch_raw;
            end else begin
                n_pitch = -PI_Q30 - pitch_raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang[0] <= r_s2[CORDIC_STAGES].yaw;
        r_ang[1] <= n_pitch;
        r_ang[2] <= r_s2[CORDIC_STAGES].roll;
    end

    // degrees: q30 angle times 180/pi in q20, split in two partial products
    logic [43:0]        r_lo [3];
    logic signed [46:0] r_hi [3];
    logic signed [63:0] deg_sum [3];
    logic [8:0]         deg [3];

    for (genvar a = 0; a < 3; a++) begin : g_deg
        always_ff @(posedge i_clk) begin
            r_lo[a] <= 44'(r_ang[a][16:0]) * 44'(unsigned'(RAD2DEG));
            r_hi[a] <= 47'($signed(r_ang[a][ZW-1:17])) * 47'(RAD2DEG);
        end

        always_comb begin
            deg_sum[a] = (64'(r_hi[a]) <<< 17) + 64'(r_lo[a]) + DEG_OFS;
            if (deg_sum[a][63]) begin
                deg[a] = '0;
            end else if (deg_sum[a][63:50] > 14'd360) begin
                deg[a] = 9'd360;
            end else begin
                deg[a] = deg_sum[a][58:50];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_yaw_deg   <= deg[0];
        o_pitch_deg <= deg[1];
        o_roll_deg  <= deg[2];
    end

    // every request comes out after the fixed latency
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("request lost in pipeline");

    // angles stay in the clamped range
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_yaw_deg <= 9'd360) && (o_pitch_deg <= 9'd360)
                    && (o_roll_deg <= 9'd360))
        else $error("angle out of range");

    // reset empties the pipeline
    a_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

// ===== rtl/core/qypr_cell.sv =====
// one cordic vectoring step, registered
// depends on qypr_pkg
module qypr_cell
    import qypr_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_idx,
    input  t_cord            i_in,
    output t_cord            o_out
);

    t_cord r_out;
    t_cord n_out;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;

    always_comb begin
        dx = i_in.y >>> i_idx;
        dy = i_in.x >>> i_idx;
        n_out.zero = i_in.zero;
        if (!i_in.y[XW-1]) begin
            n_out.x = i_in.x + dx;
            n_out.y = i_in.y - dy;
            n_out.z = i_in.z + atan_q30(i_idx);
        end else begin
            n_out.x = i_in.x - dx;
            n_out.y = i_in.y + dy;
            n_out.z = i_in.z - atan_q30(i_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out = r_out;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for quaternion_to_yaw_pitch_roll_top: random and corner quaternions
// depends on qypr_pkg and the rtl of the block; predicts angles with a local cordic model
`timescale 1ns / 100ps

module testbench;
    import qypr_pkg::*;

    localparam longint PI_Q = 64'sd3373259426;
    localparam int     WDOG_LIMIT = 4000;

    typedef struct {
        logic signed [15:0] w, x, y, z;
    } t_quat;

    typedef struct {
        logic [8:0] yaw, pitch, roll;
    } t_angles;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_quat_w, i_quat_x, i_quat_y, i_quat_z;
    logic               o_valid;
    logic [8:0]         o_yaw_deg, o_pitch_deg, o_roll_deg;

    t_quat   pending_reqs[$];
    t_angles expected_angles[$];
    int      errors;
    int      results_seen;
    int      gap_left;
    int      idle_cycles;
    bit      stim_done;
    bit      drain_hold;

    quaternion_to_yaw_pitch_roll_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_quat_w   (i_quat_w),
        .i_quat_x   (i_quat_x),
        .i_quat_y   (i_quat_y),
        .i_quat_z   (i_quat_z),
        .o_valid    (o_valid),
        .o_yaw_deg  (o_yaw_deg),
        .o_pitch_deg(o_pitch_deg),
        .o_roll_deg (o_roll_deg)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // arctangent of stage i, radians in q30
    function automatic longint stage_angle(input int i);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                            524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                            2047, 1023, 511, 255, 127};
        return tbl[i];
    endfunction

    // vectoring cordic; >>> on longint floors toward minus infinity
    function automatic longint vec_angle(input longint xin, input longint yin,
                                         output longint radius);
        longint ax, ay, az, dx, dy;
        ax = xin;
        ay = yin;
        az = 0;
        radius = 0;
        if (ax == 0 && ay == 0) return 0;
        if (ax < 0) begin
            az = (ay >= 0) ? PI_Q : -PI_Q;
            ax = -ax;
            ay = -ay;
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = ay >>> i;
            dy = ax >>> i;
            if (ay >= 0) begin
                ax += dx; ay -= dy; az += stage_angle(i);
            end else begin
                ax -= dx; ay += dy; az -= stage_angle(i);
            end
        end
        radius = ax;
        return az;
    endfunction

    // q30 radians to clamped whole degrees, offset by 180
    function automatic logic [8:0] to_whole_deg(input longint a);
        longint v, d;
        v = a * 64'sd60078979 + (64'sd180 <<< 50);
        if (v < 0) return 9'd0;
        d = v >>> 50;
        if (d > 360) d = 360;
        return d[8:0];
    endfunction

    function automatic t_angles predict_angles(input t_quat q);
        longint w, x, y, z, yy, yx, gx, gy, gz, raw_r, mag, dummy, yaw, pitch, roll;
        t_angles r;
        w = q.w; x = q.x; y = q.y; z = q.z;
        yy = 2 * (x * y) - 2 * (w * z);
        yx = 2 * (w * w) + 2 * (x * x) - (64'sd1 <<< 28);
        gx = 2 * (x * z - w * y);
        gy = 2 * (w * x + y * z);
        gz = w * w - x * x - y * y + z * z;
        yaw = vec_angle(yx, yy, dummy);
        roll = vec_angle(gz, gy, raw_r);
        // radius is never negative, so the unsigned scaling is a plain shift
        mag = (raw_r * 64'sd39797) >>> 16;
        pitch = vec_angle(mag, gx, dummy);
        // fold pitch into the back half when gravity z points down
        if (gz < 0) pitch = (pitch > 0) ? PI_Q - pitch : -PI_Q - pitch;
        r.yaw = to_whole_deg(yaw);
        r.pitch = to_whole_deg(pitch);
        r.roll = to_whole_deg(roll);
        return r;
    endfunction

    function automatic t_quat make_quat(input int w, input int x, input int y, input int z);
        t_quat q;
        q.w = w; q.x = x; q.y = y; q.z = z;
        return q;
    endfunction

    // mostly unit-ish quaternions, some full-range noise and small values
    function automatic logic signed [15:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return $urandom_range(0, 32768) - 16384;
        if (sel < 8) return $urandom;
        if (sel < 9) return $urandom_range(0, 8) - 4;
        return ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
    endfunction

    // stimulus list: corners first, then random requests
    initial begin
        int c[6] = '{0, 1, -1, 16384, -32768, 32767};
        pending_reqs.push_back(make_quat(0, 0, 0, 0));
        pending_reqs.push_back(make_quat(16384, 0, 0, 0));
        pending_reqs.push_back(make_quat(-16384, 0, 0, 0));
        pending_reqs.push_back(make_quat(0, 16384, 0, 0));
        pending_reqs.push_back(make_quat(0, 0, 16384, 0));
        pending_reqs.push_back(make_quat(0, 0, 0, 16384));
        pending_reqs.push_back(make_quat(11585, 11585, 0, 0));
        pending_reqs.push_back(make_quat(11585, 0, 11585, 0));
        pending_reqs.push_back(make_quat(11585, 0, -11585, 0));
        pending_reqs.push_back(make_quat(11585, 0, 0, 11585));
        pending_reqs.push_back(make_quat(0, 11585, 11585, 0));
        pending_reqs.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_reqs.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_reqs.push_back(make_quat(-32768, 32767, -32768, 32767));
        pending_reqs.push_back(make_quat(0, -32768, 0, 0));
        pending_reqs.push_back(make_quat(0, 0, 0, -1));
        pending_reqs.push_back(make_quat(1, 0, 0, 0));
        for (int i = 0; i < 8; i++)
            pending_reqs.push_back(make_quat(c[$urandom_range(0, 5)], c[$urandom_range(0, 5)],
                                             c[$urandom_range(0, 5)], c[$urandom_range(0, 5)]));
        for (int i = 0; i < 500; i++)
            pending_reqs.push_back(make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
    end

    // request driver with random gaps and one full drain midway
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
            drain_hold <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_angles.push_back(predict_angles(make_quat(i_quat_w, i_quat_x,
                                                                   i_quat_y, i_quat_z)));
                void'(pending_reqs.pop_front());
            end
            if (start && busy) begin
                // hold the same request until taken
            end else if (pending_reqs.size() == 260 && !drain_hold && start) begin
                start <= 1'b0;
                drain_hold <= 1'b1;
            end else if (drain_hold && expected_angles.size() != 0) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                // a request just taken is already off the head of the list
                if (pending_reqs.size() > 0) begin
                    start <= 1'b1;
                    i_quat_w <= pending_reqs[0].w;
                    i_quat_x <= pending_reqs[0].x;
                    i_quat_y <= pending_reqs[0].y;
                    i_quat_z <= pending_reqs[0].z;
                    // bursts, short gaps and the odd long one
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4, 5: gap_left <= $urandom_range(1, 3);
                        6:       gap_left <= $urandom_range(20, 60);
                        default: gap_left <= 0;
                    endcase
                end else begin
                    start <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (o_valid) begin
                results_seen <= results_seen + 1;
                if (expected_angles.size() == 0) begin
                    $error("result with no request outstanding");
                    errors = errors + 1;
                end else begin
                    t_angles e;
                    e = expected_angles.pop_front();
                    if (o_yaw_deg !== e.yaw) begin
                        $error("yaw_deg expected %0d got %0d", e.yaw, o_yaw_deg);
                        errors = errors + 1;
                    end
                    if (o_pitch_deg !== e.pitch) begin
                        $error("pitch_deg expected %0d got %0d", e.pitch, o_pitch_deg);
                        errors = errors + 1;
                    end
                    if (o_roll_deg !== e.roll) begin
                        $error("roll_deg expected %0d got %0d", e.roll, o_roll_deg);
                        errors = errors + 1;
                    end
                end
            end
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout with %0d results outstanding", expected_angles.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // reset, then wait for the queues to empty plus the pipeline depth
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_quat_w = '0; i_quat_x = '0; i_quat_y = '0; i_quat_z = '0;
        errors = 0;
        results_seen = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        drain_hold = 1'b0;
        gap_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_angles.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d quaternions: corner components, unit rotations", results_seen);
        $display("and random samples, with gaps and one full drain");
        if (errors == 0 && expected_angles.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/qypr_pkg.sv
rtl/core/qypr_cell.sv
rtl/core/quaternion_to_yaw_pitch_roll_top.sv
bench/testbench.sv
